// ----- rtl/sdspi_pkg.sv -----
package sdspi_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned BIDX_W = 10;

  typedef enum logic [2:0] {
    CMD_INIT  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_CARD  = 3'd3,
    CMD_HOST  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_CMD0    = 4'd1,
    ST_V2_A41  = 4'd2,
    ST_V1_A41  = 4'd3,
    ST_CMD1    = 4'd4,
    ST_CMD16   = 4'd5,
    ST_READ    = 4'd6,
    ST_WR_CMD  = 4'd7,
    ST_WR_DATA = 4'd8
  } status_t;

  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_MMC     = 3'd1;
  localparam logic [2:0] KIND_SD_V1   = 3'd2;
  localparam logic [2:0] KIND_SD_V2   = 3'd3;
  localparam logic [2:0] KIND_SDHC    = 3'd4;

  localparam logic [1:0] REG_RETRY = 2'd0;
  localparam logic [1:0] REG_POLL  = 2'd1;
  localparam logic [1:0] REG_DUMMY = 2'd2;
  localparam logic [1:0] REG_GAP   = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE, PH_DUMMY, PH_CMD0, PH_CMD8, PH_CMD8_TAIL, PH_V2_CMD55, PH_V2_ACMD41,
    PH_CMD58, PH_CMD58_TAIL, PH_V1_CMD55A, PH_V1_ACMD41A, PH_V1_CMD55, PH_V1_ACMD41,
    PH_CMD1, PH_CMD16, PH_INIT_TAIL, PH_RD_CMD, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC,
    PH_RD_TAIL, PH_WR_CMD, PH_WR_GAP, PH_WR_READY, PH_WR_TOKEN, PH_WR_HOST,
    PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY, PH_WR_TAIL
  } phase_t;

  typedef enum logic [2:0] {
    SND_NONE, SND_FF, SND_FE, SND_FRAME, SND_DATA
  } snd_t;

  typedef struct packed {
    logic [31:0] sector;
    logic [7:0]  data;
    cmd_t        cmd;
  } req_t;

  typedef struct packed {
    logic [7:0] retry_lim;
    logic [7:0] poll_lim;
    logic [7:0] dummy_bytes;
    logic [7:0] gap_bytes;
  } cfg_t;

  typedef struct packed {
    snd_t    snd;
    logic    cs;
    logic    need;
    logic    rdv;
    logic    done;
    status_t status;
  } act_t;

  function automatic logic is_cmd_phase(input phase_t p);
    return p == PH_CMD0 || p == PH_CMD8 || p == PH_V2_CMD55 || p == PH_V2_ACMD41 ||
           p == PH_CMD58 || p == PH_V1_CMD55A || p == PH_V1_ACMD41A ||
           p == PH_V1_CMD55 || p == PH_V1_ACMD41 || p == PH_CMD1 || p == PH_CMD16 ||
           p == PH_RD_CMD || p == PH_WR_CMD;
  endfunction

  function automatic logic [7:0] frame_byte(input phase_t p, input logic [2:0] k,
                                            input logic [31:0] a);
    logic [47:0] f;
    begin
      unique case (p)
        PH_RD_CMD:                    f = {8'h51, a, 8'hFF};
        PH_WR_CMD:                    f = {8'h58, a, 8'hFF};
        PH_CMD0:                      f = 48'h40_00_00_00_00_95;
        PH_CMD8:                      f = 48'h48_00_00_01_AA_87;
        PH_V2_ACMD41:                 f = 48'h69_40_00_00_00_01;
        PH_V1_ACMD41A, PH_V1_ACMD41:  f = 48'h69_00_00_00_00_01;
        PH_CMD58:                     f = 48'h7A_00_00_00_00_01;
        PH_CMD1:                      f = 48'h41_00_00_00_00_01;
        PH_CMD16:                     f = 48'h50_00_00_02_00_01;
        default:                      f = 48'h77_00_00_00_00_01;
      endcase
      unique case (k)
        3'd0:    return f[47:40];
        3'd1:    return f[39:32];
        3'd2:    return f[31:24];
        3'd3:    return f[23:16];
        3'd4:    return f[15:8];
        default: return f[7:0];
      endcase
    end
  endfunction

endpackage

// ----- rtl/sd_spi_init_and_block_access_core.sv -----
// a request is written into the queue, and any result it causes is then captured in the result
// register; throughput: one request per cycle, and the sequencer retires one queued
// request each cycle while the result register is not stalled; the input stalls only
// when the two-entry queue is full behind a stalled result register
// reset (rst_n low, synchronous) empties the queue and result register, puts the sequencer
// in idle with card kind unknown, and loads the register defaults 200, 200, 10 and 100
module sd_spi_init_and_block_access_core import sdspi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_sector_address,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_card_selected,
  output logic        out_need_write_byte,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_done_res,
  output logic [3:0]  out_status,
  output logic [2:0]  out_card_kind,
  output logic        out_fast_clock
);

  cfg_t cfg_r;
  logic wr_en;
  logic q_full, push, pop, head_valid;
  req_t push_req, head_req;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{retry_lim: 8'd200, poll_lim: 8'd200, dummy_bytes: 8'd10, gap_bytes: 8'd100};
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_RETRY: cfg_r.retry_lim <= pwdata[7:0];
        REG_POLL:  cfg_r.poll_lim <= pwdata[7:0];
        REG_DUMMY: cfg_r.dummy_bytes <= pwdata[7:0];
        REG_GAP:   cfg_r.gap_bytes <= pwdata[7:0];
        default:   cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RETRY: prdata = {24'd0, cfg_r.retry_lim};
      REG_POLL:  prdata = {24'd0, cfg_r.poll_lim};
      REG_DUMMY: prdata = {24'd0, cfg_r.dummy_bytes};
      REG_GAP:   prdata = {24'd0, cfg_r.gap_bytes};
      default:   prdata = 32'd0;
    endcase
  end

  sdspi_front u_front (
    .in_valid(in_valid), .in_command(in_command), .in_sector_address(in_sector_address),
    .in_data_byte(in_data_byte), .q_full(q_full), .in_stall(in_stall),
    .push(push), .push_req(push_req)
  );

  sdspi_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_req(push_req), .pop(pop),
    .head_valid(head_valid), .head_req(head_req), .full(q_full)
  );

  sdspi_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head_valid(head_valid), .head_req(head_req),
    .pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_tx_valid(out_tx_valid), .out_tx_byte(out_tx_byte),
    .out_card_selected(out_card_selected), .out_need_write_byte(out_need_write_byte),
    .out_read_valid(out_read_valid), .out_read_byte(out_read_byte),
    .out_done_res(out_done_res), .out_status(out_status),
    .out_card_kind(out_card_kind), .out_fast_clock(out_fast_clock)
  );

`ifndef ASSERT_OFF
  // a finished request sends nothing more
  a_done_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_tx_valid)
    else $error("done result carries a spi byte");

  // sector bytes arrive only while the card is selected and clocked
  a_read_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_tx_valid && out_card_selected)
    else $error("read byte outside a selected exchange");

  // waiting for host data pauses the spi side
  a_need_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_need_write_byte |-> !out_tx_valid && !out_done_res)
    else $error("write byte request with spi byte or done");
`endif

endmodule

// ----- rtl/sdspi_front.sv -----
module sdspi_front import sdspi_pkg::*; (
  input  logic        in_valid,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_sector_address,
  input  logic [7:0]  in_data_byte,
  input  logic        q_full,
  output logic        in_stall,
  output logic        push,
  output req_t        push_req
);

  logic known;

  // codes above host write byte never cause a result, drop them here
  assign known = (in_command == CMD_INIT) || (in_command == CMD_READ) ||
                 (in_command == CMD_WRITE) || (in_command == CMD_CARD) ||
                 (in_command == CMD_HOST);

  assign in_stall = q_full;
  assign push = in_valid && !q_full && known;
  assign push_req.sector = in_sector_address;
  assign push_req.data = in_data_byte;
  assign push_req.cmd = cmd_t'(in_command);

endmodule

// ----- rtl/sdspi_queue.sv -----
module sdspi_queue import sdspi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output logic head_valid,
  output req_t head_req,
  output logic full
);

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head_valid = cnt_r != 2'd0;
  assign full = cnt_r == 2'd2;
  assign head_req = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_req;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/sdspi_back.sv -----
module sdspi_back import sdspi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  req_t        head_req,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_card_selected,
  output logic        out_need_write_byte,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_done_res,
  output logic [3:0]  out_status,
  output logic [2:0]  out_card_kind,
  output logic        out_fast_clock
);

  phase_t            ph_r, ph_nxt;
  logic [7:0]        rc_r, rc_nxt, pc_r, pc_nxt;
  logic [BIDX_W-1:0] bi_r, bi_nxt;
  logic [2:0]        fi_r, fi_nxt, kd_r, kd_nxt;
  logic              ba_r, ba_nxt, fst_r, fst_nxt;
  logic [31:0]       rs_r, rs_nxt, ad_r, ad_nxt;

  logic              ov_r, ov_nxt;
  logic              txv_r, cs_r, need_r, rdv_r, done_r, fast_r;
  logic [7:0]        txb_r, rdb_r;
  logic [3:0]        st_r;
  logic [2:0]        kind_r;

  act_t              act;
  logic              produce;
  logic [7:0]        rc_inc, pc_inc, b;
  logic [BIDX_W-1:0] bi_inc;
  logic [31:0]       rs_sh;
  logic              use_retry, r_ok;
  phase_t            r_next, r_again;
  status_t           r_err;

  logic              o_txv, o_cs, o_rdv;
  logic [7:0]        o_txb, o_rdb;
  logic [3:0]        o_st;

  assign pop = head_valid && (!ov_r || !out_stall);
  assign b = head_req.data;
  assign rc_inc = rc_r + 8'd1;
  assign pc_inc = pc_r + 8'd1;
  assign bi_inc = bi_r + BIDX_W'(1);
  assign rs_sh = {rs_r[23:0], b};

  // next state of the sequencer and the action the request causes
  always_comb begin
    ph_nxt = ph_r; rc_nxt = rc_r; pc_nxt = pc_r; bi_nxt = bi_r; fi_nxt = fi_r;
    kd_nxt = kd_r; ba_nxt = ba_r; fst_nxt = fst_r; rs_nxt = rs_r; ad_nxt = ad_r;
    act = '{snd: SND_NONE, cs: 1'b0, need: 1'b0, rdv: 1'b0, done: 1'b0, status: ST_OK};
    produce = 1'b0;
    use_retry = 1'b0; r_ok = 1'b0; r_next = PH_IDLE; r_again = PH_IDLE; r_err = ST_OK;
    if (pop) begin
      unique case (head_req.cmd)
        CMD_INIT: begin
          if (ph_r == PH_IDLE) begin
            produce = 1'b1;
            kd_nxt = KIND_UNKNOWN; ba_nxt = 1'b0; fst_nxt = 1'b0; rc_nxt = '0;
            act.snd = SND_FF;
            if (cfg.dummy_bytes != 8'd0) begin
              ph_nxt = PH_DUMMY; bi_nxt = '0;
            end else begin
              ph_nxt = PH_CMD0; fi_nxt = '0;
            end
          end
        end
        CMD_READ, CMD_WRITE: begin
          if (ph_r == PH_IDLE) begin
            produce = 1'b1;
            ad_nxt = ba_r ? head_req.sector : {head_req.sector[22:0], 9'd0};
            rc_nxt = '0; fi_nxt = '0; act.snd = SND_FF;
            ph_nxt = (head_req.cmd == CMD_READ) ? PH_RD_CMD : PH_WR_CMD;
          end
        end
        CMD_HOST: begin
          if (ph_r == PH_WR_HOST) begin
            produce = 1'b1; ph_nxt = PH_WR_DATA; act.snd = SND_DATA; act.cs = 1'b1;
          end
        end
        CMD_CARD: begin
          if (ph_r != PH_IDLE && ph_r != PH_WR_HOST) begin
            produce = 1'b1;
            if (is_cmd_phase(ph_r)) begin
              if (fi_r < 3'd6) begin
                fi_nxt = fi_r + 3'd1; act.snd = SND_FRAME; act.cs = 1'b1;
              end else if (fi_r == 3'd6) begin
                fi_nxt = 3'd7; pc_nxt = '0; act.snd = SND_FF; act.cs = 1'b1;
              end else begin
                pc_nxt = pc_inc;
                if (b[7] && pc_inc < cfg.poll_lim) begin
                  act.snd = SND_FF; act.cs = 1'b1;
                end else begin
                  // response in hand
                  unique case (ph_r)
                    PH_CMD0: begin
                      use_retry = 1'b1; r_ok = b == 8'h01; r_next = PH_CMD8;
                      r_err = ST_CMD0; r_again = PH_CMD0;
                    end
                    PH_CMD8: begin
                      if (b == 8'h01) begin
                        ph_nxt = PH_CMD8_TAIL; bi_nxt = '0; rs_nxt = '0;
                        act.snd = SND_FF; act.cs = 1'b1;
                      end else begin
                        ph_nxt = PH_V1_CMD55A; fi_nxt = '0; act.snd = SND_FF;
                      end
                    end
                    PH_V2_CMD55: begin
                      ph_nxt = PH_V2_ACMD41; fi_nxt = '0; act.snd = SND_FF;
                    end
                    PH_V2_ACMD41: begin
                      use_retry = 1'b1; r_ok = b == 8'h00; r_next = PH_CMD58;
                      r_err = ST_V2_A41; r_again = PH_V2_CMD55;
                    end
                    PH_CMD58: begin
                      if (b == 8'h00) begin
                        ph_nxt = PH_CMD58_TAIL; bi_nxt = '0; rs_nxt = '0;
                        act.snd = SND_FF; act.cs = 1'b1;
                      end else begin
                        ph_nxt = PH_CMD16; fi_nxt = '0; act.snd = SND_FF;
                      end
                    end
                    PH_V1_CMD55A: begin
                      ph_nxt = PH_V1_ACMD41A; fi_nxt = '0; act.snd = SND_FF;
                    end
                    PH_V1_ACMD41A: begin
                      rc_nxt = '0; fi_nxt = '0; act.snd = SND_FF;
                      if (b <= 8'h01) begin
                        kd_nxt = KIND_SD_V1; ph_nxt = PH_V1_CMD55;
                      end else begin
                        kd_nxt = KIND_MMC; ph_nxt = PH_CMD1;
                      end
                    end
                    PH_V1_CMD55: begin
                      ph_nxt = PH_V1_ACMD41; fi_nxt = '0; act.snd = SND_FF;
                    end
                    PH_V1_ACMD41: begin
                      use_retry = 1'b1; r_ok = b == 8'h00; r_next = PH_CMD16;
                      r_err = ST_V1_A41; r_again = PH_V1_CMD55;
                    end
                    PH_CMD1: begin
                      use_retry = 1'b1; r_ok = b == 8'h00; r_next = PH_CMD16;
                      r_err = ST_CMD1; r_again = PH_CMD1;
                    end
                    PH_CMD16: begin
                      if (b != 8'h00) begin
                        kd_nxt = KIND_UNKNOWN; ph_nxt = PH_IDLE;
                        act.done = 1'b1; act.status = ST_CMD16;
                      end else begin
                        ph_nxt = PH_INIT_TAIL; act.snd = SND_FF;
                      end
                    end
                    PH_RD_CMD, PH_WR_CMD: begin
                      rc_nxt = rc_inc;
                      if (b == 8'h00) begin
                        act.snd = SND_FF; act.cs = 1'b1;
                        if (ph_r == PH_RD_CMD) begin
                          ph_nxt = PH_RD_TOKEN;
                        end else begin
                          bi_nxt = '0;
                          ph_nxt = (cfg.gap_bytes != 8'd0) ? PH_WR_GAP : PH_WR_READY;
                        end
                      end else if (rc_inc >= cfg.retry_lim) begin
                        ph_nxt = PH_IDLE; act.done = 1'b1;
                        act.status = (ph_r == PH_RD_CMD) ? ST_READ : ST_WR_CMD;
                      end else begin
                        fi_nxt = '0; act.snd = SND_FF;
                      end
                    end
                    default: ph_nxt = PH_IDLE;
                  endcase
                  if (use_retry) begin
                    rc_nxt = rc_inc;
                    if (r_ok) begin
                      rc_nxt = '0; ph_nxt = r_next; fi_nxt = '0; act.snd = SND_FF;
                    end else if (rc_inc >= cfg.retry_lim) begin
                      ph_nxt = PH_IDLE; act.done = 1'b1; act.status = r_err;
                    end else begin
                      ph_nxt = r_again; fi_nxt = '0; act.snd = SND_FF;
                    end
                  end
                end
              end
            end else begin
              unique case (ph_r)
                PH_DUMMY: begin
                  bi_nxt = bi_inc; act.snd = SND_FF;
                  if (bi_inc >= {2'b00, cfg.dummy_bytes}) begin
                    rc_nxt = '0; ph_nxt = PH_CMD0; fi_nxt = '0;
                  end
                end
                PH_CMD8_TAIL, PH_CMD58_TAIL: begin
                  rs_nxt = rs_sh; bi_nxt = bi_inc;
                  if (bi_inc < BIDX_W'(4)) begin
                    act.snd = SND_FF; act.cs = 1'b1;
                  end else begin
                    fi_nxt = '0; act.snd = SND_FF;
                    if (ph_r == PH_CMD8_TAIL) begin
                      rc_nxt = '0;
                      ph_nxt = (rs_sh[15:0] == 16'h01AA) ? PH_V2_CMD55 : PH_CMD16;
                    end else begin
                      ph_nxt = PH_CMD16;
                      if (rs_sh[30]) begin
                        kd_nxt = KIND_SDHC; ba_nxt = 1'b1;
                      end else begin
                        kd_nxt = KIND_SD_V2;
                      end
                    end
                  end
                end
                PH_INIT_TAIL: begin
                  fst_nxt = 1'b1; ph_nxt = PH_IDLE; act.done = 1'b1;
                end
                PH_RD_TOKEN: begin
                  if (b == 8'hFE) begin
                    ph_nxt = PH_RD_DATA; bi_nxt = '0;
                  end
                  act.snd = SND_FF; act.cs = 1'b1;
                end
                PH_RD_DATA: begin
                  act.rdv = 1'b1; bi_nxt = bi_inc; act.snd = SND_FF; act.cs = 1'b1;
                  if (bi_inc >= BIDX_W'(BLOCK_BYTES)) begin
                    ph_nxt = PH_RD_CRC; bi_nxt = '0;
                  end
                end
                PH_RD_CRC: begin
                  bi_nxt = bi_inc; act.snd = SND_FF;
                  if (bi_inc < BIDX_W'(2)) begin
                    act.cs = 1'b1;
                  end else begin
                    ph_nxt = PH_RD_TAIL;
                  end
                end
                PH_WR_GAP: begin
                  bi_nxt = bi_inc; act.snd = SND_FF; act.cs = 1'b1;
                  if (bi_inc >= {2'b00, cfg.gap_bytes}) begin
                    ph_nxt = PH_WR_READY;
                  end
                end
                PH_WR_READY: begin
                  act.cs = 1'b1;
                  if (b == 8'hFF) begin
                    ph_nxt = PH_WR_TOKEN; act.snd = SND_FE;
                  end else begin
                    act.snd = SND_FF;
                  end
                end
                PH_WR_TOKEN: begin
                  ph_nxt = PH_WR_HOST; bi_nxt = '0; act.need = 1'b1;
                end
                PH_WR_DATA: begin
                  bi_nxt = bi_inc;
                  if (bi_inc < BIDX_W'(BLOCK_BYTES)) begin
                    ph_nxt = PH_WR_HOST; act.need = 1'b1;
                  end else begin
                    ph_nxt = PH_WR_CRC; bi_nxt = '0; act.snd = SND_FF; act.cs = 1'b1;
                  end
                end
                PH_WR_CRC: begin
                  bi_nxt = bi_inc; act.snd = SND_FF; act.cs = 1'b1;
                  if (bi_inc >= BIDX_W'(2)) begin
                    ph_nxt = PH_WR_RESP;
                  end
                end
                PH_WR_RESP: begin
                  if (b[4:0] != 5'h05) begin
                    ph_nxt = PH_IDLE; act.done = 1'b1; act.status = ST_WR_DATA;
                  end else begin
                    ph_nxt = PH_WR_BUSY; act.snd = SND_FF; act.cs = 1'b1;
                  end
                end
                PH_WR_BUSY: begin
                  act.snd = SND_FF;
                  if (b == 8'hFF) begin
                    ph_nxt = PH_WR_TAIL;
                  end else begin
                    act.cs = 1'b1;
                  end
                end
                PH_RD_TAIL, PH_WR_TAIL: begin
                  ph_nxt = PH_IDLE; act.done = 1'b1;
                end
                default: ph_nxt = PH_IDLE;
              endcase
            end
          end
        end
        default: produce = 1'b0;
      endcase
    end
  end

  // result fields from the action
  always_comb begin
    o_txv = act.snd != SND_NONE;
    o_cs = o_txv && act.cs;
    unique case (act.snd)
      SND_FF:    o_txb = 8'hFF;
      SND_FE:    o_txb = 8'hFE;
      SND_FRAME: o_txb = frame_byte(ph_r, fi_r, ad_r);
      SND_DATA:  o_txb = b;
      default:   o_txb = 8'h00;
    endcase
    o_rdv = act.rdv;
    o_rdb = act.rdv ? b : 8'h00;
    o_st = act.done ? act.status : ST_OK;
  end

  assign ov_nxt = produce || (ov_r && out_stall);

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      txv_r <= o_txv; txb_r <= o_txb; cs_r <= o_cs; need_r <= act.need;
      rdv_r <= o_rdv; rdb_r <= o_rdb; done_r <= act.done; st_r <= o_st;
      kind_r <= kd_nxt; fast_r <= fst_nxt;
    end
    rs_r <= rs_nxt;
    ad_r <= ad_nxt;
    if (!rst_n) begin
      ph_r <= PH_IDLE; rc_r <= '0; pc_r <= '0; bi_r <= '0; fi_r <= '0;
      kd_r <= KIND_UNKNOWN; ba_r <= 1'b0; fst_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; rc_r <= rc_nxt; pc_r <= pc_nxt; bi_r <= bi_nxt; fi_r <= fi_nxt;
      kd_r <= kd_nxt; ba_r <= ba_nxt; fst_r <= fst_nxt; ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_tx_valid = txv_r;
  assign out_tx_byte = txb_r;
  assign out_card_selected = cs_r;
  assign out_need_write_byte = need_r;
  assign out_read_valid = rdv_r;
  assign out_read_byte = rdb_r;
  assign out_done_res = done_r;
  assign out_status = st_r;
  assign out_card_kind = kind_r;
  assign out_fast_clock = fast_r;

endmodule
